[hdl/pixel_demote_premultiply_core_macros.svh]
// Assertion macros shared by the pixel demote and premultiply RTL.
`ifndef PIXEL_DEMOTE_PREMULTIPLY_CORE_MACROS_SVH
`define PIXEL_DEMOTE_PREMULTIPLY_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PDP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pdp_pkg.sv]
// Types, constants and sample functions for the pixel demote and premultiply core.
package pdp_pkg;

    typedef logic [15:0] sample_t;

    localparam int unsigned LANES = 3;

    localparam sample_t FULL_DEEP = 16'd32768;
    localparam sample_t FULL_BYTE = 16'd255;

    localparam logic [1:0] REG_DEEP_SAMPLES       = 2'd0;
    localparam logic [1:0] REG_COLOR_PIXELS       = 2'd1;
    localparam logic [1:0] REG_ALPHA_PRESENT      = 2'd2;
    localparam logic [1:0] REG_PREMULTIPLY_ENABLE = 2'd3;

    typedef struct packed {
        logic load;
        logic deep;
        logic mul_en;
    } pdp_stage_t;

    function automatic sample_t demote(input sample_t v);
        sample_t vm1;
        begin
            vm1 = v - 16'd1;
            if (v > FULL_DEEP)
                demote = {1'b0, vm1[15:1]} + 16'd1;
            else
                demote = {1'b0, v[15:1]};
        end
    endfunction

    function automatic sample_t take_sample(input sample_t raw, input logic deep);
        begin
            if (deep)
                take_sample = demote(raw);
            else
                take_sample = {8'd0, raw[7:0]};
        end
    endfunction

endpackage

[hdl/pdp_lane.sv]
// One colour lane: alpha product register and rounded division by full scale.
module pdp_lane (
    input  logic                clk,
    input  pdp_pkg::pdp_stage_t ctl,
    input  pdp_pkg::sample_t    sample,
    input  pdp_pkg::sample_t    alpha,
    output pdp_pkg::sample_t    result
);
    import pdp_pkg::*;

    sample_t     alpha_op;
    logic [30:0] prod_next;
    logic [30:0] prod_reg;
    logic        deep_reg;
    logic [30:0] deep_sum;
    logic [16:0] byte_bias;
    logic [16:0] byte_sum;

    always_comb
    begin
        if (ctl.mul_en)
            alpha_op = alpha;
        else if (ctl.deep)
            alpha_op = FULL_DEEP;
        else
            alpha_op = FULL_BYTE;
        prod_next = {15'd0, sample} * {15'd0, alpha_op};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            prod_reg <= prod_next;
            deep_reg <= ctl.deep;
        end
    end

    always_comb
    begin
        deep_sum  = prod_reg + 31'd16384;
        byte_bias = prod_reg[16:0] + 17'd128;
        byte_sum  = byte_bias + {8'd0, byte_bias[16:8]};
        if (deep_reg)
            result = deep_sum[30:15];
        else
            result = {8'd0, byte_sum[15:8]};
    end

endmodule

[hdl/pdp_merge.sv]
// Output stage: gathers lane results, alpha and last into the outgoing transfer.
module pdp_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [pdp_pkg::LANES-1:0][15:0] lane_result,
    input  pdp_pkg::sample_t              alpha,
    input  logic                          last,
    output logic                          take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,  // result_first, result_second,
                                                    // result_third, result_alpha
    output logic                          m_tlast
);
    import pdp_pkg::*;

    logic        valid_reg;
    logic [63:0] data_reg;
    logic        last_reg;

    assign take = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
        begin
            data_reg <= {alpha, lane_result[2], lane_result[1], lane_result[0]};
            last_reg <= last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

[hdl/pixel_demote_premultiply_core.sv]
// Top level of the pixel demote and premultiply core.
//  channel | direction | carries
//  s_*     | in        | tdata: sample_first..sample_alpha, tlast: last_in
//  m_*     | out       | tdata: result_first..result_alpha, tlast: last_out
//  cfg_*   | in        | register writes, index 0..3, bit 0 of data kept
// One pixel per cycle while m_tready is high; valid passes v1_reg and v2_reg before m_tvalid.
// Stages: sample select and demotion, one 16x16 product per lane, rounding into output.
// A stall at the output fills the pipeline; s_tready drops only once all stages hold data.
// Reset clears valid flags and sets registers to 8-bit, colour, alpha, no premultiply.
`include "pixel_demote_premultiply_core_macros.svh"
module pixel_demote_premultiply_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_first, sample_second, sample_third, sample_alpha
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result_first, result_second, result_third, result_alpha
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);
    import pdp_pkg::*;

    logic deep_reg;
    logic color_reg;
    logic alpha_en_reg;
    logic premul_reg;

    logic                     v1_reg;
    logic [LANES-1:0][15:0]   c1_reg;
    sample_t                  a1_reg;
    logic                     deep1_reg;
    logic                     mul1_reg;
    logic                     last1_reg;

    logic                     v2_reg;
    sample_t                  a2_reg;
    logic                     last2_reg;

    logic                     take;
    logic                     load2;
    logic                     load1;
    logic                     s_xfer;
    pdp_stage_t               lane_ctl;
    logic [LANES-1:0][15:0]   lane_result;
    sample_t                  a_next;
    logic [LANES-1:0][15:0]   c_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deep_reg     <= 1'b0;
            color_reg    <= 1'b1;
            alpha_en_reg <= 1'b1;
            premul_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEEP_SAMPLES:       deep_reg     <= cfg_data;
                REG_COLOR_PIXELS:       color_reg    <= cfg_data;
                REG_ALPHA_PRESENT:      alpha_en_reg <= cfg_data;
                REG_PREMULTIPLY_ENABLE: premul_reg   <= cfg_data;
                default:                deep_reg     <= deep_reg;
            endcase
        end
    end

    assign load2    = !v2_reg || take;
    assign load1    = !v1_reg || load2;
    assign s_tready = load1;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb
    begin
        c_next[0] = take_sample(s_tdata[15:0], deep_reg);
        c_next[1] = color_reg ? take_sample(s_tdata[31:16], deep_reg) : 16'd0;
        c_next[2] = color_reg ? take_sample(s_tdata[47:32], deep_reg) : 16'd0;
        a_next    = alpha_en_reg ? take_sample(s_tdata[63:48], deep_reg) : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (load1)
                v1_reg <= s_tvalid;
            if (load2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            c1_reg    <= c_next;
            a1_reg    <= a_next;
            deep1_reg <= deep_reg;
            mul1_reg  <= premul_reg && alpha_en_reg;
            last1_reg <= s_tlast;
        end
        if (load2 && v1_reg)
        begin
            a2_reg    <= a1_reg;
            last2_reg <= last1_reg;
        end
    end

    always_comb
    begin
        lane_ctl.load   = load2 && v1_reg;
        lane_ctl.deep   = deep1_reg;
        lane_ctl.mul_en = mul1_reg;
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        pdp_lane u_lane (
            .clk    (clk),
            .ctl    (lane_ctl),
            .sample (c1_reg[i]),
            .alpha  (a1_reg),
            .result (lane_result[i])
        );
    end

    pdp_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v2_reg),
        .lane_result (lane_result),
        .alpha       (a2_reg),
        .last        (last2_reg),
        .take        (take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    `PDP_ASSERT_NOW(a_stall_full, v1_reg && !s_tready,
        v2_reg && m_tvalid && !m_tready, "input stalled while pipeline not full")
    `PDP_ASSERT_NEXT(a_stage2_hold, v2_reg && !take, v2_reg,
        "stage two data lost during output stall")
    `PDP_ASSERT_NOW(a_first_range, m_tvalid, m_tdata[15:0] <= FULL_DEEP,
        "result_first above full scale")
    `PDP_ASSERT_NOW(a_alpha_range, m_tvalid, m_tdata[63:48] <= FULL_DEEP,
        "result_alpha above full scale")

endmodule
